[src/crqb_pkg.sv]
// Shared types and constants for the confirm/retransmit queue with backoff.
// Used by confirm_retransmit_queue_backoff_unit; no other dependencies.
package crqb_pkg;

   localparam int KIND_COUNT  = 4;
   localparam int TAG_BITS    = 64;
   localparam int HANDLE_BITS = 32;

   localparam int KIND_BITS    = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
   localparam int CNT_BITS     = $clog2(KIND_COUNT + 1);
   localparam int BUF_DEPTH    = (KIND_COUNT < 2) ? 2 : KIND_COUNT;
   localparam int BUF_IDX_BITS = $clog2(BUF_DEPTH);
   localparam int EMIT_BITS    = $clog2(BUF_DEPTH + 1);

   localparam int INIT_BITS    = 11;
   localparam int LIMIT_BITS   = 16;
   localparam int BACKOFF_BITS = 17;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [INIT_BITS-1:0]  INIT_BACKOFF_RESET = INIT_BITS'(2);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET        = LIMIT_BITS'(60 * 10);
   localparam logic [31:0]           NEXT_ATTEMPT_RESET = 32'd2;

   typedef logic [1:0] action_type;
   localparam action_type ACT_ENQUEUE = 2'd0;
   localparam action_type ACT_CONFIRM = 2'd1;
   localparam action_type ACT_FETCH   = 2'd2;

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_INIT_BACKOFF  = CSR_IDX_BITS'(0);
   localparam csr_index_type CSR_BACKOFF_LIMIT = CSR_IDX_BITS'(1);

   typedef enum logic [2:0] {
      RK_SAVED      = 3'd0,
      RK_REMOVED    = 3'd1,
      RK_CONFIRM    = 3'd2,
      RK_RESEND     = 3'd3,
      RK_NONE_HELD  = 3'd4
   } result_kind_type;

   typedef struct packed {
      result_kind_type         rkind;
      logic [1:0]              ekind;
      logic [TAG_BITS-1:0]     tag;
      logic [HANDLE_BITS-1:0]  handle;
      logic                    confirmed;
   } res_entry_type;

endpackage

[src/confirm_retransmit_queue_backoff_unit.sv]
// Retransmit queue for one peer: at most one unconfirmed message per kind,
// exponential resend backoff. Depends on crqb_pkg.
//
// Usage: a request is taken when start is high and busy is low. The cycle
// after, the request is worked in one pass against the held entries and its
// results (one to four) land in a small result buffer; they then leave one
// per cycle on the rsp_ ports, each flagged by rsp_strobe for exactly one
// cycle, rsp_last on the final one. The receiver cannot stall, so results
// must be consumed as they appear. busy falls during the final result cycle,
// so the next request can be taken while the last result leaves. Action 3,
// or an enqueue with a kind beyond the slot count, yields no result.
// Configuration (csr_) is always ready and must only be written while the
// block is idle.
module confirm_retransmit_queue_backoff_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_action,
   input  logic [1:0]                          req_msg_kind,
   input  logic [63:0]                         req_txn_tag,
   input  logic [31:0]                         req_msg_handle,
   input  logic [31:0]                         req_now_seconds,
   // result channel
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_result_kind,
   output logic [1:0]                          rsp_entry_kind,
   output logic [63:0]                         rsp_entry_tag,
   output logic [31:0]                         rsp_entry_handle,
   output logic                                rsp_confirmed,
   output logic [31:0]                         rsp_next_attempt_time,
   output logic [2:0]                          rsp_held_count,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crqb_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [crqb_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import crqb_pkg::*;

   // configuration registers
   logic [INIT_BITS-1:0]    init_backoff_ff;
   logic [LIMIT_BITS-1:0]   backoff_limit_ff;

   // captured request
   logic                    pend_ff, pend_in;
   action_type              act_ff;
   logic [1:0]              kind_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   logic [HANDLE_BITS-1:0]  handle_ff;
   logic [31:0]             now_ff;

   // held entries, one slot per kind
   logic [KIND_COUNT-1:0]   slot_valid_ff, slot_valid_in;
   logic [TAG_BITS-1:0]     slot_tag_ff [KIND_COUNT];
   logic [HANDLE_BITS-1:0]  slot_handle_ff [KIND_COUNT];
   logic                    slot_write;
   logic [KIND_BITS-1:0]    kind_idx;

   // backoff timer state
   logic [BACKOFF_BITS-1:0] backoff_ff, backoff_in;
   logic [31:0]             next_attempt_ff, next_attempt_in;

   // result buffer and drain counters
   res_entry_type           res_buf_ff [BUF_DEPTH];
   res_entry_type           res_buf_in [BUF_DEPTH];
   logic [EMIT_BITS-1:0]    num_res;
   logic [EMIT_BITS-1:0]    emit_left_ff, emit_left_in;
   logic [BUF_IDX_BITS-1:0] emit_idx_ff, emit_idx_in;
   logic [CNT_BITS-1:0]     held_ff, held_in;
   logic [CNT_BITS-1:0]     held_before;
   logic [31:0]             res_next_ff;

   // fetch ordering: position of each held slot in ascending tag order
   logic [CNT_BITS-1:0]     rank [KIND_COUNT];

   res_entry_type           cur;

   assign csr_ready = 1'b1;
   assign busy      = pend_ff || (emit_left_ff > EMIT_BITS'(1));
   assign pend_in   = start && !busy;
   assign kind_idx  = KIND_BITS'(kind_ff);

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         init_backoff_ff  <= INIT_BACKOFF_RESET;
         backoff_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INIT_BACKOFF:  init_backoff_ff  <= csr_data[INIT_BITS-1:0];
            CSR_BACKOFF_LIMIT: backoff_limit_ff <= csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         act_ff    <= req_action;
         kind_ff   <= req_msg_kind;
         tag_ff    <= req_txn_tag[TAG_BITS-1:0];
         handle_ff <= req_msg_handle[HANDLE_BITS-1:0];
         now_ff    <= req_now_seconds;
      end
   end

   // ---------------- ranking of held tags ----------------
   // Ties (cannot happen among held tags) resolve by kind.
   always_comb begin
      for (int k = 0; k < KIND_COUNT; k++) begin
         rank[k] = '0;
         for (int j = 0; j < KIND_COUNT; j++) begin
            if (j != k && slot_valid_ff[j] &&
                (slot_tag_ff[j] < slot_tag_ff[k] ||
                 (slot_tag_ff[j] == slot_tag_ff[k] && j < k))) begin
               rank[k] = rank[k] + CNT_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      held_before = '0;
      for (int k = 0; k < KIND_COUNT; k++) begin
         held_before = held_before + CNT_BITS'(slot_valid_ff[k]);
      end
   end

   always_comb begin
      held_in = '0;
      for (int k = 0; k < KIND_COUNT; k++) begin
         held_in = held_in + CNT_BITS'(slot_valid_in[k]);
      end
   end

   // ---------------- single-pass request processing ----------------
   always_comb begin
      res_entry_type save_e;
      logic          found;

      slot_valid_in   = slot_valid_ff;
      slot_write      = 1'b0;
      backoff_in      = backoff_ff;
      next_attempt_in = next_attempt_ff;
      num_res         = '0;
      found           = 1'b0;
      for (int p = 0; p < BUF_DEPTH; p++) begin
         res_buf_in[p] = res_buf_ff[p];
      end

      save_e.rkind     = RK_SAVED;
      save_e.ekind     = kind_ff;
      save_e.tag       = tag_ff;
      save_e.handle    = handle_ff;
      save_e.confirmed = 1'b0;

      if (pend_ff) begin
         case (act_ff)
            ACT_ENQUEUE: begin
               if (int'(kind_ff) < KIND_COUNT) begin
                  if (slot_valid_ff[kind_idx]) begin
                     res_buf_in[0].rkind     = RK_REMOVED;
                     res_buf_in[0].ekind     = kind_ff;
                     res_buf_in[0].tag       = slot_tag_ff[kind_idx];
                     res_buf_in[0].handle    = slot_handle_ff[kind_idx];
                     res_buf_in[0].confirmed = 1'b0;
                     res_buf_in[1]           = save_e;
                     num_res                 = EMIT_BITS'(2);
                  end else begin
                     res_buf_in[0] = save_e;
                     num_res       = EMIT_BITS'(1);
                  end
                  // another kind holding the same tag is dropped silently
                  for (int k = 0; k < KIND_COUNT; k++) begin
                     if (slot_valid_ff[k] && slot_tag_ff[k] == tag_ff) begin
                        slot_valid_in[k] = 1'b0;
                     end
                  end
                  slot_valid_in[kind_idx] = 1'b1;
                  slot_write              = 1'b1;
               end
            end
            ACT_CONFIRM: begin
               res_buf_in[0].rkind     = RK_CONFIRM;
               res_buf_in[0].ekind     = '0;
               res_buf_in[0].tag       = '0;
               res_buf_in[0].handle    = '0;
               res_buf_in[0].confirmed = 1'b0;
               num_res                 = EMIT_BITS'(1);
               // lowest kind with a matching tag wins
               for (int k = 0; k < KIND_COUNT; k++) begin
                  if (!found && slot_valid_ff[k] && slot_tag_ff[k] == tag_ff) begin
                     found                   = 1'b1;
                     slot_valid_in[k]        = 1'b0;
                     res_buf_in[0].ekind     = 2'(k);
                     res_buf_in[0].tag       = slot_tag_ff[k];
                     res_buf_in[0].handle    = slot_handle_ff[k];
                     res_buf_in[0].confirmed = 1'b1;
                  end
               end
               if (found) begin
                  backoff_in = BACKOFF_BITS'(init_backoff_ff);
               end
            end
            ACT_FETCH: begin
               if (backoff_ff < BACKOFF_BITS'(backoff_limit_ff)) begin
                  backoff_in = {backoff_ff[BACKOFF_BITS-2:0], 1'b0};
               end
               next_attempt_in = now_ff + 32'(backoff_in);
               if (held_before == '0) begin
                  res_buf_in[0].rkind     = RK_NONE_HELD;
                  res_buf_in[0].ekind     = '0;
                  res_buf_in[0].tag       = '0;
                  res_buf_in[0].handle    = '0;
                  res_buf_in[0].confirmed = 1'b0;
                  num_res                 = EMIT_BITS'(1);
               end else begin
                  num_res = EMIT_BITS'(held_before);
                  for (int p = 0; p < BUF_DEPTH; p++) begin
                     for (int k = 0; k < KIND_COUNT; k++) begin
                        if (slot_valid_ff[k] && rank[k] == CNT_BITS'(p)) begin
                           res_buf_in[p].rkind     = RK_RESEND;
                           res_buf_in[p].ekind     = 2'(k);
                           res_buf_in[p].tag       = slot_tag_ff[k];
                           res_buf_in[p].handle    = slot_handle_ff[k];
                           res_buf_in[p].confirmed = 1'b0;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- drain counters ----------------
   always_comb begin
      emit_left_in = emit_left_ff;
      emit_idx_in  = emit_idx_ff;
      if (pend_ff) begin
         emit_left_in = num_res;
         emit_idx_in  = '0;
      end else if (emit_left_ff != '0) begin
         emit_left_in = emit_left_ff - EMIT_BITS'(1);
         emit_idx_in  = emit_idx_ff + BUF_IDX_BITS'(1);
      end
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff   <= '0;
         backoff_ff      <= BACKOFF_BITS'(INIT_BACKOFF_RESET);
         next_attempt_ff <= NEXT_ATTEMPT_RESET;
         emit_left_ff    <= '0;
         emit_idx_ff     <= '0;
      end else begin
         slot_valid_ff   <= slot_valid_in;
         backoff_ff      <= backoff_in;
         next_attempt_ff <= next_attempt_in;
         emit_left_ff    <= emit_left_in;
         emit_idx_ff     <= emit_idx_in;
      end
   end

   // payload: slot contents, result buffer, per-request common fields
   always_ff @(posedge clock) begin
      if (slot_write) begin
         slot_tag_ff[kind_idx]    <= tag_ff;
         slot_handle_ff[kind_idx] <= handle_ff;
      end
      for (int p = 0; p < BUF_DEPTH; p++) begin
         res_buf_ff[p] <= res_buf_in[p];
      end
      if (pend_ff) begin
         held_ff     <= held_in;
         res_next_ff <= next_attempt_in;
      end
   end

   // ---------------- result ports ----------------
   assign cur                   = res_buf_ff[emit_idx_ff];
   assign rsp_strobe            = (emit_left_ff != '0);
   assign rsp_last              = (emit_left_ff == EMIT_BITS'(1));
   assign rsp_result_kind       = cur.rkind;
   assign rsp_entry_kind        = cur.ekind;
   assign rsp_entry_tag         = 64'(cur.tag);
   assign rsp_entry_handle      = 32'(cur.handle);
   assign rsp_confirmed         = cur.confirmed;
   assign rsp_next_attempt_time = res_next_ff;
   assign rsp_held_count        = 3'(held_ff);

endmodule
